/* hdl/pnf_pkg.sv */
// ----------------------------------------------------------------------------
// pnf_pkg
// Shared types, constants and the gradient function of the fractal noise core.
// ----------------------------------------------------------------------------
package pnf_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int TBL_W      = $clog2(TABLE_SIZE);
  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 24;
  localparam int OCT_W      = 5;
  localparam int ACC_W      = 36;
  localparam int DEN_W      = 16;

  localparam logic [OCT_W-1:0] MAX_OCTAVES = 5'd16;
  localparam logic [OCT_W-1:0] OCT_RESET   = 5'd12;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FADE,
    ST_READ,
    ST_BLEND,
    ST_DIVI,
    ST_DIV,
    ST_DONE
  } pnf_state_e;

  // Improved noise gradient, selected by the low four hash bits.
  function automatic logic signed [18:0] grad(input logic [3:0] h,
                                              input logic signed [17:0] x,
                                              input logic signed [17:0] y,
                                              input logic signed [17:0] z);
    logic signed [18:0] u;
    logic signed [18:0] v;
    u = (h < 4'd8) ? 19'(x) : 19'(y);
    if (h < 4'd4) v = 19'(y);
    else if (h == 4'd12 || h == 4'd14) v = 19'(x);
    else v = 19'(z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

endpackage

/* hdl/pnf_if.sv */
// ----------------------------------------------------------------------------
// pnf_if
// Valid/ready channels: request (load or evaluate) and noise result.
// ----------------------------------------------------------------------------
interface pnf_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  entry_index;
  logic [7:0]  entry_value;
  logic [23:0] coord_x;
  logic [23:0] coord_y;
  logic [23:0] coord_z;

  modport source(output valid, operation, entry_index, entry_value,
                 coord_x, coord_y, coord_z, input ready);
  modport sink(input valid, operation, entry_index, entry_value,
               coord_x, coord_y, coord_z, output ready);
endinterface

interface pnf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] noise_out;
  logic        [7:0]  pixel_level;

  modport source(output valid, noise_out, pixel_level, input ready);
  modport sink(input valid, noise_out, pixel_level, output ready);
endinterface

/* hdl/pnf_ram.sv */
// ----------------------------------------------------------------------------
// pnf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pnf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/perlin_noise_fbm_3d_core.sv */
// ----------------------------------------------------------------------------
// perlin_noise_fbm_3d_core
// Each octave runs a fade, a table read and a lerp phase, with fade and lerp
// on one shared multiplier; divider setup, the 36-step divider and output follow.
// A load writes the table without leaving idle; one item is handled at a time,
// since requests are taken only in the idle state.
// Reset: asynchronous, active low; table reads as identity, octave count 12.
// ----------------------------------------------------------------------------
module perlin_noise_fbm_3d_core
  import pnf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [OCT_W-1:0] cfg_data_i,
  pnf_in_if.sink           req_i,
  pnf_out_if.source        rsp_o
);

  pnf_state_e state_q, state_d;

  logic [5:0]        step_q, step_d;
  logic              ph_q, ph_d;
  logic [OCT_W-1:0]  octcfg_q;
  logic [OCT_W-1:0]  n_q, n_d, oct_q, oct_d;
  logic [TABLE_SIZE-1:0] valid_q;
  logic              out_valid_q;

  logic [COORD_W-1:0] px_q, py_q, pz_q;
  logic [15:0]        fade_q [3];
  logic [20:0]        p16_q;
  logic [15:0]        sq_q, cu_q;
  logic [TBL_W-1:0]   a_q, b_q, aa_q, ab_q, ba_q, bb_q;
  logic [3:0]         hash_q [8];
  logic signed [18:0] ea_q;
  logic signed [19:0] ed_q;
  logic signed [18:0] r_q [6];
  logic signed [ACC_W-1:0] acc_q;
  logic               neg_q;
  logic [ACC_W-1:0]   mag_q;
  logic [DEN_W-1:0]   rem_q, den_q;
  logic               rvld_q;
  logic [TBL_W-1:0]   raddr_q;
  logic signed [15:0] noise_q;
  logic [7:0]         pix_q;

  logic in_xfer, out_xfer, is_eval, last_oct, out_free;
  assign in_xfer  = req_i.valid & req_i.ready;
  assign out_xfer = rsp_o.valid & rsp_o.ready;
  assign is_eval  = req_i.operation == OP_EVAL;
  assign last_oct = oct_q == n_q - 5'd1;
  assign out_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    if (octcfg_q == '0) n_d = 5'd1;
    else if (octcfg_q > MAX_OCTAVES) n_d = MAX_OCTAVES;
    else n_d = octcfg_q;
  end

  // ---------------- permutation table ----------------
  logic             we;
  logic [TBL_W-1:0] raddr, rd;
  logic [TBL_W-1:0] ram_rdata;

  assign we = in_xfer && !is_eval;

  pnf_ram #(.WIDTH(TBL_W), .DEPTH(TABLE_SIZE)) u_tbl (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (req_i.entry_index),
    .wdata_i (req_i.entry_value),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // entries never loaded read as identity
  assign rd = rvld_q ? ram_rdata : raddr_q;

  logic [TBL_W-1:0] cx, cy, cz;
  assign cx = px_q[COORD_W-1:FRAC_BITS];
  assign cy = py_q[COORD_W-1:FRAC_BITS];
  assign cz = pz_q[COORD_W-1:FRAC_BITS];

  always_comb begin
    case (step_q[3:0])
      4'd0:    raddr = cx;
      4'd1:    raddr = cx + 8'd1;
      4'd2:    raddr = a_q;
      4'd3:    raddr = a_q + 8'd1;
      4'd4:    raddr = b_q;
      4'd5:    raddr = b_q + 8'd1;
      4'd6:    raddr = aa_q;
      4'd7:    raddr = ba_q;
      4'd8:    raddr = ab_q;
      4'd9:    raddr = bb_q;
      4'd10:   raddr = aa_q + 8'd1;
      4'd11:   raddr = ba_q + 8'd1;
      4'd12:   raddr = ab_q + 8'd1;
      4'd13:   raddr = bb_q + 8'd1;
      default: raddr = cx;
    endcase
  end

  // ---------------- shared multiplier ----------------
  logic signed [21:0] mul_a;
  logic        [15:0] mul_b;
  logic signed [38:0] prod, p_sum;
  logic        [15:0] t;
  logic signed [21:0] s1;
  logic        [15:0] f_sel;

  always_comb begin
    case (step_q[3:2])
      2'd1:    t = py_q[FRAC_BITS-1:0];
      2'd2:    t = pz_q[FRAC_BITS-1:0];
      default: t = px_q[FRAC_BITS-1:0];
    endcase
  end

  assign s1 = $signed(({6'b0, t} << 2) + ({6'b0, t} << 1) - 22'd983040);

  always_comb begin
    case (step_q[2:0])
      3'd2, 3'd5: f_sel = fade_q[1];
      3'd6:       f_sel = fade_q[2];
      default:    f_sel = fade_q[0];
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_FADE) begin
      case (step_q[1:0])
        2'd0:    begin mul_a = s1;                    mul_b = t;    end
        2'd1:    begin mul_a = $signed({6'b0, t});    mul_b = t;    end
        2'd2:    begin mul_a = $signed({6'b0, sq_q}); mul_b = t;    end
        default: begin mul_a = $signed({1'b0, p16_q}); mul_b = cu_q; end
      endcase
    end else if (state_q == ST_BLEND) begin
      mul_a = 22'(ed_q);
      mul_b = f_sel;
    end
  end

  assign prod  = mul_a * $signed({1'b0, mul_b});
  assign p_sum = prod + 39'sd42949672960;

  // ---------------- lerp operands ----------------
  logic signed [17:0] fx0, fy0, fz0, fx1, fy1, fz1;
  assign fx0 = $signed({2'b0, px_q[FRAC_BITS-1:0]});
  assign fy0 = $signed({2'b0, py_q[FRAC_BITS-1:0]});
  assign fz0 = $signed({2'b0, pz_q[FRAC_BITS-1:0]});
  assign fx1 = fx0 - 18'sd65536;
  assign fy1 = fy0 - 18'sd65536;
  assign fz1 = fz0 - 18'sd65536;

  logic [2:0]         ja;
  logic signed [18:0] ga, gb, op_a, op_b;
  logic signed [19:0] bl_sum;
  logic signed [18:0] bl_r;

  always_comb begin
    case (step_q[2:0])
      3'd1:    ja = 3'd2;
      3'd3:    ja = 3'd4;
      3'd4:    ja = 3'd6;
      default: ja = 3'd0;
    endcase
  end

  // corner code: bit 0 selects x1, bit 1 y1, bit 2 z1
  assign ga = grad(hash_q[ja], fx0, ja[1] ? fy1 : fy0, ja[2] ? fz1 : fz0);
  assign gb = grad(hash_q[ja | 3'd1], fx1, ja[1] ? fy1 : fy0, ja[2] ? fz1 : fz0);

  always_comb begin
    case (step_q[2:0])
      3'd2:    begin op_a = r_q[0]; op_b = r_q[1]; end
      3'd5:    begin op_a = r_q[3]; op_b = r_q[4]; end
      3'd6:    begin op_a = r_q[2]; op_b = r_q[5]; end
      default: begin op_a = ga;     op_b = gb;     end
    endcase
  end

  assign bl_sum = 20'(ea_q) + $signed(prod[35:16]);
  assign bl_r   = bl_sum[18:0];

  // ---------------- divider and output ----------------
  logic [DEN_W:0]          rem_ext;
  logic                    ge;
  logic signed [ACC_W-1:0] qv, qh;
  logic signed [15:0]      noise_d;

  assign rem_ext = {rem_q, mag_q[ACC_W-1]};
  assign ge      = rem_ext >= {1'b0, den_q};

  always_comb begin
    qv = neg_q ? -$signed(mag_q) : $signed(mag_q);
    qh = qv >>> 1;
    if (qh > 36'sd32767) noise_d = 16'sd32767;
    else if (qh < -36'sd32768) noise_d = -16'sd32768;
    else noise_d = qh[15:0];
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    ph_d    = ph_q;
    oct_d   = oct_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && is_eval) begin
          state_d = ST_FADE;
          step_d  = '0;
          oct_d   = '0;
        end
      end
      ST_FADE: begin
        step_d = step_q + 6'd1;
        if (step_q == 6'd11) begin
          state_d = ST_READ;
          step_d  = '0;
          ph_d    = 1'b0;
        end
      end
      ST_READ: begin
        ph_d = !ph_q;
        if (ph_q) begin
          step_d = step_q + 6'd1;
          if (step_q == 6'd13) begin
            state_d = ST_BLEND;
            step_d  = '0;
          end
        end
      end
      ST_BLEND: begin
        ph_d = !ph_q;
        if (ph_q) begin
          step_d = step_q + 6'd1;
          if (step_q == 6'd6) begin
            step_d = '0;
            if (last_oct) state_d = ST_DIVI;
            else begin
              state_d = ST_FADE;
              oct_d   = oct_q + 5'd1;
            end
          end
        end
      end
      ST_DIVI: begin
        state_d = ST_DIV;
        step_d  = '0;
      end
      ST_DIV: begin
        step_d = step_q + 6'd1;
        if (step_q == 6'(ACC_W - 1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready       = state_q == ST_IDLE;
    rsp_o.valid       = out_valid_q;
    rsp_o.noise_out   = noise_q;
    rsp_o.pixel_level = pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      ph_q        <= 1'b0;
      oct_q       <= '0;
      n_q         <= 5'd1;
      octcfg_q    <= OCT_RESET;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ph_q    <= ph_d;
      oct_q   <= oct_d;
      if (cfg_we_i) octcfg_q <= cfg_data_i;
      if (in_xfer && is_eval) n_q <= n_d;
      if (we) valid_q[req_i.entry_index] <= 1'b1;
      if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_xfer) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rvld_q  <= valid_q[raddr];
    raddr_q <= raddr;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && is_eval) begin
          px_q  <= req_i.coord_x;
          py_q  <= req_i.coord_y;
          pz_q  <= req_i.coord_z;
          acc_q <= '0;
        end
      end
      ST_FADE: begin
        case (step_q[1:0])
          2'd0:    p16_q <= p_sum[36:16];
          2'd1:    sq_q  <= prod[31:16];
          2'd2:    cu_q  <= prod[31:16];
          default: fade_q[step_q[3:2]] <= prod[31:16];
        endcase
      end
      ST_READ: begin
        if (ph_q) begin
          case (step_q[3:0])
            4'd0:    a_q  <= rd + cy;
            4'd1:    b_q  <= rd + cy;
            4'd2:    aa_q <= rd + cz;
            4'd3:    ab_q <= rd + cz;
            4'd4:    ba_q <= rd + cz;
            4'd5:    bb_q <= rd + cz;
            default: hash_q[3'(step_q[3:0] - 4'd6)] <= rd[3:0];
          endcase
        end
      end
      ST_BLEND: begin
        if (!ph_q) begin
          ea_q <= op_a;
          ed_q <= 20'(op_b) - 20'(op_a);
        end else if (step_q[2:0] == 3'd6) begin
          acc_q <= (acc_q <<< 1) + ACC_W'(bl_r);
          // next octave samples the point at twice the scale
          px_q  <= px_q << 1;
          py_q  <= py_q << 1;
          pz_q  <= pz_q << 1;
        end else begin
          r_q[step_q[2:0]] <= bl_r;
        end
      end
      ST_DIVI: begin
        neg_q <= acc_q[ACC_W-1];
        mag_q <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
        rem_q <= '0;
        den_q <= DEN_W'((17'd1 << n_q) - 17'd1);
      end
      ST_DIV: begin
        rem_q <= ge ? DEN_W'(rem_ext - {1'b0, den_q}) : rem_ext[DEN_W-1:0];
        mag_q <= {mag_q[ACC_W-2:0], ge};
      end
      ST_DONE: begin
        if (out_free) begin
          noise_q <= noise_d;
          pix_q   <= {~noise_d[15], noise_d[14:8]};
        end
      end
      default: ;
    endcase
  end

  // ---------------- assertions ----------------
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !is_eval && !out_valid_q) |=> !out_valid_q)
    else $error("load produced a result");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && is_eval) |=> !req_i.ready)
    else $error("ready after evaluation start");

  a_read_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (step_q < 6'd14))
    else $error("table read step out of range");

  a_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (pix_q == {~noise_q[15], noise_q[14:8]}))
    else $error("pixel level disagrees with noise");

  a_octaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (n_q >= 5'd1 && n_q <= MAX_OCTAVES && oct_q < n_q))
    else $error("octave count out of range");

endmodule
